FILE: rtl/bounded_integer_set_table_unit_defines.svh
// assertion helpers for the set table unit
`ifndef BOUNDED_INTEGER_SET_TABLE_UNIT_DEFINES_SVH
`define BOUNDED_INTEGER_SET_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define BIST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define BIST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bist_pkg.sv
package bist_pkg;

    localparam int CAPACITY  = 64;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = 38;
    localparam int COUNT_W   = 7;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALLOWED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALLOWED = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT_CHECKED   = 2'd0,
        FN_INSERT_UNCHECKED = 2'd1,
        FN_REMOVE           = 2'd2,
        FN_CONTAINS         = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    // request token that walks down the cell chain
    typedef struct packed {
        logic              active;
        t_func             func;
        logic [DATA_W-1:0] value;
        logic              allow;   // range check passed (or not needed)
        logic              hit;     // value matched in an earlier cell
        logic              placed;  // value already written into a free cell
    } t_token;

endpackage

FILE: rtl/bounded_integer_set_table_unit.sv
// Set table of up to CAPACITY distinct signed 32-bit values held in a row of
// cells, one value per cell, filled from cell 0 upward. A request is taken
// when start is high and busy is low; it then walks the row one cell per
// cycle through every cell, whatever the operation and fill level, with
// busy high until the result is registered. The result sits on the result
// ports flagged by o_done, which is high for a single cycle; the receiver
// cannot stall it, so it must be captured then. Configuration writes are
// always ready and take effect from the next request. No clearing pass is
// needed after reset.
`include "bounded_integer_set_table_unit_defines.svh"

module bounded_integer_set_table_unit
    import bist_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       start,
    output logic                       busy,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic signed [DATA_W-1:0]   i_element_value,
    // result channel
    output logic                       o_done,
    output logic [STATUS_W-1:0]        o_status,
    output logic                       o_found,
    output logic [COUNT_W-1:0]         o_entry_count,
    output logic signed [SUM_W-1:0]    o_entry_sum,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [DATA_W-1:0]          i_cfg_data
);

    // range limits for checked inserts
    logic signed [DATA_W-1:0] r_min_allowed;
    logic signed [DATA_W-1:0] r_max_allowed;

    // controller state
    t_state                   r_state;
    t_state                   n_state;
    t_token                   r_tok;        // token entering cell 0
    logic [COUNT_W-1:0]       r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_done;
    t_status                  r_status;
    logic                     r_found;

    // chain wiring: index CAPACITY is past the last cell
    t_token                   w_tok   [0:CAPACITY];
    logic [DATA_W-1:0]        w_entry [0:CAPACITY];
    logic                     w_valid [0:CAPACITY];
    logic [CAPACITY:0]        w_active;

    logic                     w_accept;
    logic                     w_in_range;
    t_func                    w_func;
    t_token                   w_exit;
    logic signed [SUM_W-1:0]  w_ext;
    t_status                  w_status;
    logic                     w_remove_hit;

    assign w_accept = start && !busy;
    assign w_func   = t_func'(i_func);
    assign w_in_range = (i_element_value >= r_min_allowed) &&
                        (i_element_value <= r_max_allowed);

    // ---------------- configuration port ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_allowed <= {1'b1, {(DATA_W-1){1'b0}}};
            r_max_allowed <= {1'b0, {(DATA_W-1){1'b1}}};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_ALLOWED: r_min_allowed <= i_cfg_data;
                CFG_MAX_ALLOWED: r_max_allowed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- token injection ----------------
    // range check done once here, cells only see the verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= w_accept;
            if (w_accept) begin
                r_tok.func   <= w_func;
                r_tok.value  <= i_element_value;
                r_tok.allow  <= (w_func != FN_INSERT_CHECKED) || w_in_range;
                r_tok.hit    <= 1'b0;
                r_tok.placed <= 1'b0;
            end
        end
    end

    // ---------------- cell chain ----------------
    assign w_tok[0]          = r_tok;
    assign w_entry[CAPACITY] = '0;
    assign w_valid[CAPACITY] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bist_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (w_tok[g]),
            .i_next_entry (w_entry[g+1]),
            .i_next_valid (w_valid[g+1]),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_tok        (w_tok[g+1])
        );
    end

    for (genvar g = 0; g <= CAPACITY; g++) begin : g_active
        assign w_active[g] = w_tok[g].active;
    end

    // ---------------- result formation ----------------
    assign w_exit       = w_tok[CAPACITY];
    assign w_ext        = SUM_W'(signed'(w_exit.value));
    assign w_remove_hit = (w_exit.func == FN_REMOVE) && w_exit.hit;

    always_comb begin
        w_status = ST_OK;
        case (w_exit.func)
            FN_INSERT_CHECKED: begin
                if (!w_exit.allow) begin
                    w_status = ST_RANGE;
                end else if (w_exit.hit) begin
                    w_status = ST_DUP;
                end else if (!w_exit.placed) begin
                    w_status = ST_FULL;
                end
            end
            FN_INSERT_UNCHECKED: begin
                if (!w_exit.hit && !w_exit.placed) begin
                    w_status = ST_FULL;
                end
            end
            default: w_status = ST_OK;
        endcase
    end

    // count and sum follow what the cells did to the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (w_exit.active) begin
            if (w_exit.placed) begin
                r_count <= r_count + COUNT_W'(1);
                r_sum   <= r_sum + w_ext;
            end else if (w_remove_hit) begin
                r_count <= r_count - COUNT_W'(1);
                r_sum   <= r_sum - w_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_exit.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit.active) begin
            r_status <= w_status;
            r_found  <= w_exit.hit;
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_exit.active) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_entry_count = r_count;
    assign o_entry_sum   = r_sum;

    // ---------------- checks ----------------
    // only one request may be in the chain
    `BIST_ASSERT_IMPL(a_one_token, 1'b1, $onehot0(w_active), "more than one token in chain")
    // token leaving the last cell yields a result next cycle
    `BIST_ASSERT_NEXT(a_exit_done, w_exit.active, o_done, "result strobe missing")
    // no new request while one is walking
    `BIST_ASSERT_IMPL(a_busy_walk, w_active != '0, busy, "busy low with token in chain")
    // full status only with every cell occupied
    `BIST_ASSERT_IMPL(a_full_count, o_done && (o_status == ST_FULL), r_count == COUNT_W'(CAPACITY), "full status with free cells")

endmodule

FILE: rtl/bist_cell.sv
module bist_cell
    import bist_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_token            i_tok,
    input  logic [DATA_W-1:0] i_next_entry,
    input  logic              i_next_valid,
    output logic [DATA_W-1:0] o_entry,
    output logic              o_valid,
    output t_token            o_tok
);

    logic [DATA_W-1:0] r_entry;
    logic              r_valid;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_match;
    logic              w_hit;
    logic              w_place;
    logic              w_shift;
    logic              w_is_insert;

    assign w_is_insert = (i_tok.func == FN_INSERT_CHECKED) ||
                         (i_tok.func == FN_INSERT_UNCHECKED);
    assign w_match = i_tok.active && r_valid && (r_entry == i_tok.value) && !i_tok.hit;
    assign w_hit   = i_tok.hit || w_match;
    // first free cell seen by an insert that passed the range check and found no match
    assign w_place = i_tok.active && w_is_insert && !r_valid && !i_tok.hit &&
                     !i_tok.placed && i_tok.allow;
    // remove: this cell and all after the match pull from the right neighbor
    assign w_shift = i_tok.active && (i_tok.func == FN_REMOVE) && w_hit;

    always_comb begin
        n_tok        = i_tok;
        n_tok.hit    = w_hit;
        n_tok.placed = i_tok.placed || w_place;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_next_valid;
        end else if (w_place) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_entry <= i_next_entry;
        end else if (w_place) begin
            r_entry <= i_tok.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import bist_pkg::*;

    // run limits and handy values
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int          ITEMS_PER_PHASE = 100;
    localparam int          NUM_PHASES      = 8;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // one result as the block reports it
    typedef struct packed {
        t_status                  status;
        logic                     found;
        logic [COUNT_W-1:0]       count;
        logic signed [SUM_W-1:0]  sum;
    } t_set_result;

    // directed rows: predicted, typed-in expectation, or a range write
    typedef enum {ROW_PRED, ROW_TYPED, ROW_RANGE} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        t_func                    func;
        logic signed [DATA_W-1:0] a;     // value, or low bound for a range row
        logic signed [DATA_W-1:0] b;     // high bound for a range row
        t_set_result              res;
    } t_dir_row;

    // operation mixes for the random phases
    typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} t_op_mix;

    // dut ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [FUNC_W-1:0]          i_func = '0;
    logic signed [DATA_W-1:0]   i_element_value = '0;
    logic                       o_done;
    logic [STATUS_W-1:0]        o_status;
    logic                       o_found;
    logic [COUNT_W-1:0]         o_entry_count;
    logic signed [SUM_W-1:0]    o_entry_sum;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [DATA_W-1:0]          i_cfg_data = '0;

    // shadow copy of the table and its range registers
    logic signed [DATA_W-1:0]   shadow_tbl [CAPACITY];
    int                         shadow_count;
    logic signed [SUM_W-1:0]    shadow_sum;
    logic signed [DATA_W-1:0]   lo_bound;
    logic signed [DATA_W-1:0]   hi_bound;

    // results still owed by the block, oldest first
    t_set_result                pending_results [$];
    t_set_result                head_result;
    t_dir_row                   dir_rows [$];

    // bookkeeping
    int unsigned                cycle_cnt;
    int                         fail_cnt;
    int                         reqs_sent;
    int                         results_seen;
    int                         n_found;
    int                         n_dup;
    int                         n_range;
    int                         n_full;

    bounded_integer_set_table_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_element_value (i_element_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_entry_count   (o_entry_count),
        .o_entry_sum     (o_entry_sum),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a stuck handshake ends the run here
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("** bounded_integer_set_table_unit: FAILED **");
            $finish;
        end
    end

    // applies one request to the shadow table and returns what the block must report
    function automatic t_set_result table_op_result(t_func f, logic signed [DATA_W-1:0] v);
        t_set_result r;
        int          idx;
        int          i;
        logic        hit;
        idx = -1;
        for (i = 0; i < shadow_count; i++) begin
            if (idx < 0 && shadow_tbl[i] == v)
                idx = i;
        end
        hit = (idx >= 0);
        r.status = ST_OK;
        r.found  = hit;
        case (f)
            FN_INSERT_CHECKED: begin
                // range beats duplicate, duplicate beats full
                if (v < lo_bound || v > hi_bound)
                    r.status = ST_RANGE;
                else if (hit)
                    r.status = ST_DUP;
                else if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else begin
                    shadow_tbl[shadow_count] = v;
                    shadow_count++;
                    shadow_sum = shadow_sum + v;
                end
            end
            FN_INSERT_UNCHECKED: begin
                // duplicates pass silently, only a full table is an error
                if (!hit) begin
                    if (shadow_count >= CAPACITY)
                        r.status = ST_FULL;
                    else begin
                        shadow_tbl[shadow_count] = v;
                        shadow_count++;
                        shadow_sum = shadow_sum + v;
                    end
                end
            end
            FN_REMOVE: begin
                // close the gap by moving later entries down one place
                if (hit) begin
                    for (i = idx; i + 1 < shadow_count; i++)
                        shadow_tbl[i] = shadow_tbl[i + 1];
                    shadow_count--;
                    shadow_sum = shadow_sum - v;
                end
            end
            default: ;
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        r.sum   = shadow_sum;
        return r;
    endfunction

    function automatic t_dir_row mk(t_row_kind kind, t_func f, logic signed [DATA_W-1:0] a,
                                    logic signed [DATA_W-1:0] b, t_status st, logic fnd,
                                    logic [COUNT_W-1:0] cnt, logic signed [SUM_W-1:0] sum);
        t_dir_row row;
        row.kind       = kind;
        row.func       = f;
        row.a          = a;
        row.b          = b;
        row.res.status = st;
        row.res.found  = fnd;
        row.res.count  = cnt;
        row.res.sum    = sum;
        return row;
    endfunction

    // appends one row to the directed table
    task automatic add_row(t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // operation drawn according to the phase mix
    function automatic t_func pick_func(t_op_mix mix);
        int    r;
        t_func f;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                f = (r < 35) ? FN_INSERT_CHECKED : (r < 80) ? FN_INSERT_UNCHECKED :
                    (r < 85) ? FN_REMOVE : FN_CONTAINS;
            MIX_DRAIN:
                f = (r < 10) ? FN_INSERT_CHECKED : (r < 20) ? FN_INSERT_UNCHECKED :
                    (r < 80) ? FN_REMOVE : FN_CONTAINS;
            default:
                f = (r < 30) ? FN_INSERT_CHECKED : (r < 50) ? FN_INSERT_UNCHECKED :
                    (r < 80) ? FN_REMOVE : FN_CONTAINS;
        endcase
        return f;
    endfunction

    // mostly a small pool so duplicates, hits and a full table happen,
    // sometimes stored values, bounds and their neighbors, or any 32-bit word
    function automatic logic signed [DATA_W-1:0] pick_value();
        int                       r;
        logic signed [DATA_W-1:0] val;
        r = $urandom_range(0, 19);
        if (r == 0)
            val = $urandom;
        else if (r == 1) begin
            case ($urandom_range(0, 5))
                0: val = VAL_MIN;
                1: val = VAL_MAX;
                2: val = lo_bound;
                3: val = hi_bound;
                4: val = lo_bound - 1;
                default: val = hi_bound + 1;
            endcase
        end else if (r <= 5 && shadow_count > 0)
            val = shadow_tbl[$urandom_range(0, shadow_count - 1)];
        else
            val = $signed($urandom_range(0, 95)) - 48;
        return val;
    endfunction

    // one request; returns at the edge that accepts it
    task automatic send_request(t_func f, logic signed [DATA_W-1:0] v, int gap,
                                bit use_typed, t_set_result typed_res);
        t_set_result pred;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_func          <= f;
        i_element_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // predictor always runs so the shadow table stays in step
        pred = table_op_result(f, v);
        pending_results.insert(pending_results.size(), use_typed ? typed_res : pred);
        reqs_sent++;
    endtask

    // drop start and wait until the block owes nothing
    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_MIN_ALLOWED)
            lo_bound = data;
        else
            hi_bound = data;
    endtask

    // new range, only written with the block idle
    task automatic set_range(logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
        settle();
        write_reg(CFG_MIN_ALLOWED, lo);
        write_reg(CFG_MAX_ALLOWED, hi);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result checker: every strobe is matched against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d found %0d count %0d sum %0d",
                       o_status, o_found, o_entry_count, o_entry_sum);
                fail_cnt++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_status !== head_result.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           head_result.status, o_status);
                    fail_cnt++;
                end
                if (o_found !== head_result.found) begin
                    $error("found mismatch: expected %0d, got %0d",
                           head_result.found, o_found);
                    fail_cnt++;
                end
                if (o_entry_count !== head_result.count) begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           head_result.count, o_entry_count);
                    fail_cnt++;
                end
                if (o_entry_sum !== head_result.sum) begin
                    $error("entry_sum mismatch: expected %0d, got %0d",
                           head_result.sum, o_entry_sum);
                    fail_cnt++;
                end
            end
            // tally what the run reached
            if (o_found === 1'b1)
                n_found++;
            if (o_status == ST_DUP)
                n_dup++;
            if (o_status == ST_RANGE)
                n_range++;
            if (o_status == ST_FULL)
                n_full++;
        end
    end

    // stimulus
    initial begin
        int                       n;
        int                       p;
        int                       k;
        int                       gap;
        bit                       no_idle;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        t_op_mix                  mix;

        cycle_cnt    = 0;
        fail_cnt     = 0;
        reqs_sent    = 0;
        results_seen = 0;
        n_found      = 0;
        n_dup        = 0;
        n_range      = 0;
        n_full       = 0;
        shadow_count = 0;
        shadow_sum   = '0;
        lo_bound     = VAL_MIN;
        hi_bound     = VAL_MAX;
        for (n = 0; n < CAPACITY; n++)
            shadow_tbl[n] = '0;

        // directed rows, reset range first
        add_row(mk(ROW_TYPED, FN_CONTAINS, 0, 0, ST_OK, 0, 0, 0));
        add_row(mk(ROW_TYPED, FN_REMOVE, 5, 0, ST_OK, 0, 0, 0));
        add_row(mk(ROW_TYPED, FN_INSERT_CHECKED, VAL_MIN, 0, ST_OK, 0, 1,
                   -38'sd2147483648));
        add_row(mk(ROW_TYPED, FN_INSERT_CHECKED, VAL_MAX, 0, ST_OK, 0, 2, -1));
        // duplicate on checked insert
        add_row(mk(ROW_TYPED, FN_INSERT_CHECKED, VAL_MAX, 0, ST_DUP, 1, 2, -1));
        // duplicate on unchecked insert is quietly accepted
        add_row(mk(ROW_TYPED, FN_INSERT_UNCHECKED, VAL_MIN, 0, ST_OK, 1, 2, -1));
        add_row(mk(ROW_TYPED, FN_CONTAINS, VAL_MAX, 0, ST_OK, 1, 2, -1));
        add_row(mk(ROW_TYPED, FN_REMOVE, VAL_MIN, 0, ST_OK, 1, 1,
                   38'sd2147483647));
        add_row(mk(ROW_PRED, FN_INSERT_CHECKED, -1, 0, ST_OK, 0, 0, 0));
        add_row(mk(ROW_PRED, FN_INSERT_CHECKED, 0, 0, ST_OK, 0, 0, 0));
        // remove of the head entry shifts the rest down
        add_row(mk(ROW_PRED, FN_REMOVE, VAL_MAX, 0, ST_OK, 0, 0, 0));
        add_row(mk(ROW_PRED, FN_CONTAINS, 32'sh5A5A_A5A5, 0, ST_OK, 0, 0, 0));
        // narrow range, just outside and on both bounds
        add_row(mk(ROW_RANGE, FN_CONTAINS, -10, 10, ST_OK, 0, 0, 0));
        add_row(mk(ROW_TYPED, FN_INSERT_CHECKED, 11, 0, ST_RANGE, 0, 2, -1));
        add_row(mk(ROW_TYPED, FN_INSERT_CHECKED, -11, 0, ST_RANGE, 0, 2, -1));
        add_row(mk(ROW_PRED, FN_INSERT_CHECKED, 10, 0, ST_OK, 0, 0, 0));
        add_row(mk(ROW_PRED, FN_INSERT_CHECKED, -10, 0, ST_OK, 0, 0, 0));
        add_row(mk(ROW_PRED, FN_INSERT_UNCHECKED, 1000, 0, ST_OK, 0, 0, 0));
        // out of range and present: range wins, found still reported
        add_row(mk(ROW_TYPED, FN_INSERT_CHECKED, 1000, 0, ST_RANGE, 1, 5, 999));
        // empty range rejects everything checked
        add_row(mk(ROW_RANGE, FN_CONTAINS, 5, -5, ST_OK, 0, 0, 0));
        add_row(mk(ROW_TYPED, FN_INSERT_CHECKED, 0, 0, ST_RANGE, 1, 5, 999));
        add_row(mk(ROW_PRED, FN_CONTAINS, -1, 0, ST_OK, 0, 0, 0));
        add_row(mk(ROW_RANGE, FN_CONTAINS, VAL_MIN, VAL_MAX, ST_OK, 0, 0, 0));
        // middle remove, then the same value again when absent
        add_row(mk(ROW_PRED, FN_REMOVE, 10, 0, ST_OK, 0, 0, 0));
        add_row(mk(ROW_PRED, FN_REMOVE, 10, 0, ST_OK, 0, 0, 0));

        // reset held at the start, released once
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_RANGE)
                set_range(dir_rows[n].a, dir_rows[n].b);
            else
                send_request(dir_rows[n].func, dir_rows[n].a, $urandom_range(0, 6),
                             dir_rows[n].kind == ROW_TYPED, dir_rows[n].res);
        end

        // random phases, each setting a range and an operation mix;
        // the range change drains the block first
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin lo = VAL_MIN; hi = VAL_MAX; mix = MIX_BALANCED; end
                1: begin lo = -20;     hi = 20;      mix = MIX_FILL;     end
                2: begin lo = VAL_MIN; hi = VAL_MIN; mix = MIX_BALANCED; end
                3: begin lo = VAL_MAX; hi = VAL_MAX; mix = MIX_DRAIN;    end
                4: begin lo = 100;     hi = -100;    mix = MIX_FILL;     end
                5: begin lo = $urandom; hi = $urandom; mix = MIX_BALANCED; end
                6: begin lo = 0;       hi = 47;      mix = MIX_FILL;     end
                default: begin lo = VAL_MIN; hi = VAL_MAX; mix = MIX_DRAIN; end
            endcase
            set_range(lo, hi);
            no_idle = 1'b0;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // back-to-back stretches now and then
                if (k % 16 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                gap = no_idle ? 0 : $urandom_range(0, 6);
                send_request(pick_func(mix), pick_value(), gap, 1'b0, '0);
            end
        end

        // drain and let a full walk pass for any stray strobe
        settle();
        repeat (CAPACITY + 4) @(posedge i_clk);

        $display("covered %0d requests and %0d results over %0d range settings",
                 reqs_sent, results_seen, NUM_PHASES + 3);
        $display("hits %0d, duplicate %0d, out of range %0d, table full %0d",
                 n_found, n_dup, n_range, n_full);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("** bounded_integer_set_table_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never came", fail_cnt,
                     pending_results.size());
            $display("** bounded_integer_set_table_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/bist_pkg.sv
rtl/bist_cell.sv
rtl/bounded_integer_set_table_unit.sv
verif/tb.sv
